/* sv/bfpa_pkg.sv */
// Shared types and constants of the best-fit partition allocator.
package bfpa_pkg;

  localparam int IDX_W = 9;
  localparam logic [15:0] RESET_MEMORY_SIZE = 16'd640;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOOWNER = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] len;
  } blk_t;

  typedef struct packed {
    logic             init;
    logic [15:0]      init_len;
    logic             load_en;
    logic [IDX_W-1:0] load_idx;
    blk_t             load_val;
    logic             shl_en;
    logic [IDX_W-1:0] shl_from;
    logic             shr_en;
    logic [IDX_W-1:0] shr_from;
  } cell_op_t;

endpackage

/* sv/bfpa_cell.sv */
// One free-list cell holding a free block, able to shift to or from its neighbours.
module bfpa_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  bfpa_pkg::cell_op_t  op,
  input  bfpa_pkg::blk_t      left,
  input  bfpa_pkg::blk_t      right,
  output bfpa_pkg::blk_t      q
);

  localparam logic [bfpa_pkg::IDX_W-1:0] MY_IDX = bfpa_pkg::IDX_W'(IDX);

  always_ff @(posedge clk) begin
    if (op.init) begin
      q.start <= 16'd0;
      q.len   <= (IDX == 0) ? op.init_len : 16'd0;
    end else if (op.load_en && op.load_idx == MY_IDX) begin
      q <= op.load_val;
    end else if (op.shl_en && MY_IDX >= op.shl_from) begin
      q <= right;
    end else if (op.shr_en && MY_IDX > op.shr_from) begin
      q <= left;
    end
  end

endmodule

/* sv/best_fit_partition_allocator.sv */
// Top level of the best-fit partition allocator: control, owned table and the free-list chain.
// One item at a time; an allocate scans the free-list chain and then the owned table, one entry
// per cycle, and a release scans the owned table and then the free-list chain in the same way.
// The result is held in an output register until taken. Reset leaves one free block [0, 640)
// and a write of memory_size leaves one free block [0, memory_size), or none if memory_size is
// zero; both leave no owned regions.
module best_fit_partition_allocator #(
  parameter int FREE_SLOTS  = 16,
  parameter int OWNED_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  owner_id,
  input  logic [15:0] size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] start_res,
  output logic [15:0] length
);

  localparam int FI  = $clog2(FREE_SLOTS);
  localparam int CW  = $clog2(FREE_SLOTS + 1);
  localparam int OI  = (OWNED_SLOTS > 1) ? $clog2(OWNED_SLOTS) : 1;
  localparam int OCW = $clog2(OWNED_SLOTS + 1);
  localparam int IW  = bfpa_pkg::IDX_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FSCAN = 6'b000010,
    S_OSCAN = 6'b000100,
    S_PSCAN = 6'b001000,
    S_UPD   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;
  logic        kind_r;
  logic [7:0]  id_r;
  logic [15:0] sz_r;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  ci;
  logic [OCW-1:0] oj;
  logic [CW-1:0]  best_idx;
  logic [15:0]    best_start;
  logic [15:0]    best_len;
  logic           best_found;
  logic [OI-1:0]  slot;
  logic [15:0]    rs;
  logic [15:0]    amt;
  logic [15:0]    prev_start;
  logic [15:0]    prev_len;
  logic           have_prev;
  logic           left_r;
  logic           right_r;
  logic [15:0]    right_len;
  logic [CW-1:0]  p;
  logic [1:0]     res_status;
  logic [15:0]    res_start;
  logic [15:0]    res_len;
  logic [1:0]     hold_status;
  logic [15:0]    hold_start;
  logic [15:0]    hold_len;

  logic [7:0]  owned_id    [OWNED_SLOTS];
  logic [15:0] owned_start [OWNED_SLOTS];
  logic [15:0] owned_len   [OWNED_SLOTS];
  logic [OWNED_SLOTS-1:0] owned_valid;

  bfpa_pkg::blk_t     cells [FREE_SLOTS];
  bfpa_pkg::blk_t     cur;
  bfpa_pkg::cell_op_t op;
  logic [16:0] re;
  logic [16:0] prev_end;
  logic        ci_live;
  logic        oj_live;
  logic        ohit;
  logic [OI-1:0] oidx;
  logic [15:0] amt_next;

  assign in_ready  = (state == S_IDLE);
  assign status    = hold_status;
  assign start_res = hold_start;
  assign length    = hold_len;

  assign cur      = cells[ci[FI-1:0]];
  assign ci_live  = (ci < cnt);
  assign oj_live  = (oj < OCW'(OWNED_SLOTS));
  assign oidx     = oj[OI-1:0];
  assign ohit     = kind_r ? (owned_valid[oidx] && owned_id[oidx] == id_r) : !owned_valid[oidx];
  assign amt_next = (sz_r < owned_len[oidx]) ? sz_r : owned_len[oidx];
  assign re       = {1'b0, rs} + {1'b0, amt};
  assign prev_end = {1'b0, prev_start} + {1'b0, prev_len};

  genvar g;
  generate
    for (g = 0; g < FREE_SLOTS; g++) begin : g_cell
      bfpa_pkg::blk_t lft;
      bfpa_pkg::blk_t rgt;
      if (g == 0) begin : g_first
        assign lft = '0;
      end else begin : g_mid
        assign lft = cells[g-1];
      end
      if (g == FREE_SLOTS - 1) begin : g_last
        assign rgt = '0;
      end else begin : g_next
        assign rgt = cells[g+1];
      end
      bfpa_cell #(.IDX(g)) u_cell (
        .clk   (clk),
        .op    (op),
        .left  (lft),
        .right (rgt),
        .q     (cells[g])
      );
    end
  endgenerate

  always_comb begin
    op = '0;
    op.init     = rst || cfg_we;
    op.init_len = rst ? bfpa_pkg::RESET_MEMORY_SIZE : cfg_wdata;
    if (state == S_UPD && !op.init) begin
      if (!kind_r) begin
        if (best_len == sz_r) begin
          op.shl_en   = 1'b1;
          op.shl_from = IW'(best_idx);
        end else begin
          op.load_en        = 1'b1;
          op.load_idx       = IW'(best_idx);
          op.load_val.start = best_start + sz_r;
          op.load_val.len   = best_len - sz_r;
        end
      end else if (left_r) begin
        op.load_en        = 1'b1;
        op.load_idx       = IW'(p) - IW'(1);
        op.load_val.start = prev_start;
        op.load_val.len   = prev_len + amt + (right_r ? right_len : 16'd0);
        op.shl_en         = right_r;
        op.shl_from       = IW'(p);
      end else if (right_r) begin
        op.load_en        = 1'b1;
        op.load_idx       = IW'(p);
        op.load_val.start = rs;
        op.load_val.len   = right_len + amt;
      end else begin
        op.load_en        = 1'b1;
        op.load_idx       = IW'(p);
        op.load_val.start = rs;
        op.load_val.len   = amt;
        op.shr_en         = 1'b1;
        op.shr_from       = IW'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= CW'(1);
      owned_valid <= '0;
      out_valid   <= 1'b0;
    end else if (cfg_we) begin
      state       <= S_IDLE;
      cnt         <= CW'(cfg_wdata != 16'd0);
      owned_valid <= '0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid   <= 1'b1;
        hold_status <= res_status;
        hold_start  <= res_start;
        hold_len    <= res_len;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_r     <= kind;
            id_r       <= owner_id;
            sz_r       <= size;
            ci         <= '0;
            oj         <= '0;
            best_found <= 1'b0;
            have_prev  <= 1'b0;
            if (kind) begin
              state <= S_OSCAN;
            end else if (size == 16'd0) begin
              res_status <= bfpa_pkg::ST_NOFIT;
              res_start  <= '0;
              res_len    <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_FSCAN;
            end
          end
        end
        S_FSCAN: begin
          if (ci_live) begin
            if (cur.len >= sz_r && (!best_found || cur.len < best_len)) begin
              best_found <= 1'b1;
              best_idx   <= ci;
              best_start <= cur.start;
              best_len   <= cur.len;
            end
            ci <= ci + CW'(1);
          end else if (!best_found) begin
            res_status <= bfpa_pkg::ST_NOFIT;
            res_start  <= '0;
            res_len    <= '0;
            state      <= S_DONE;
          end else begin
            state <= S_OSCAN;
          end
        end
        S_OSCAN: begin
          if (oj_live) begin
            if (ohit) begin
              slot <= oidx;
              if (!kind_r) begin
                state <= S_UPD;
              end else begin
                rs  <= owned_start[oidx];
                amt <= amt_next;
                ci  <= '0;
                if (amt_next == 16'd0) begin
                  res_status <= bfpa_pkg::ST_OK;
                  res_start  <= owned_start[oidx];
                  res_len    <= '0;
                  state      <= S_DONE;
                end else begin
                  state <= S_PSCAN;
                end
              end
            end else begin
              oj <= oj + OCW'(1);
            end
          end else begin
            res_status <= kind_r ? bfpa_pkg::ST_NOOWNER : bfpa_pkg::ST_FULL;
            res_start  <= '0;
            res_len    <= '0;
            state      <= S_DONE;
          end
        end
        S_PSCAN: begin
          if (ci_live && cur.start < rs) begin
            prev_start <= cur.start;
            prev_len   <= cur.len;
            have_prev  <= 1'b1;
            ci         <= ci + CW'(1);
          end else begin
            p         <= ci;
            right_len <= cur.len;
            right_r   <= ci_live && ({1'b0, cur.start} == re);
            left_r    <= have_prev && (prev_end == {1'b0, rs});
            if (!(have_prev && prev_end == {1'b0, rs}) &&
                !(ci_live && {1'b0, cur.start} == re) && cnt >= CW'(FREE_SLOTS)) begin
              res_status <= bfpa_pkg::ST_FULL;
              res_start  <= '0;
              res_len    <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          res_status <= bfpa_pkg::ST_OK;
          if (!kind_r) begin
            owned_valid[slot] <= 1'b1;
            owned_id[slot]    <= id_r;
            owned_start[slot] <= best_start;
            owned_len[slot]   <= sz_r;
            if (best_len == sz_r) begin
              cnt <= cnt - CW'(1);
            end
            res_start <= best_start;
            res_len   <= sz_r;
          end else begin
            owned_start[slot] <= re[15:0];
            owned_len[slot]   <= owned_len[slot] - amt;
            if (owned_len[slot] == amt) begin
              owned_valid[slot] <= 1'b0;
            end
            if (left_r && right_r) begin
              cnt <= cnt - CW'(1);
            end else if (!left_r && !right_r) begin
              cnt <= cnt + CW'(1);
            end
            res_start <= rs;
            res_len   <= amt;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/sv/tb_best_fit_partition_allocator.sv */
// Self-checking testbench for the best-fit partition allocator, with its own allocation predictor.
`timescale 1ns / 100ps

module tb_best_fit_partition_allocator;

  localparam int NFREE = 16;
  localparam int NOWNED = 16;
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [1:0]  st;
    logic [15:0] addr;
    logic [15:0] len;
  } alloc_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [7:0]  owner_id;
  logic [15:0] size;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [15:0] start_res;
  logic [15:0] length;

  int unsigned   free_base[NFREE];
  int unsigned   free_len[NFREE];
  int            free_cnt;
  logic [7:0]    region_owner[NOWNED];
  int unsigned   region_base[NOWNED];
  int unsigned   region_len[NOWNED];
  bit            region_live[NOWNED];
  alloc_result_t pending_results[$];
  int            mismatches;
  int            idle_cycles;
  bit            no_gaps;
  int            hold_request;

  best_fit_partition_allocator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .owner_id(owner_id), .size(size),
    .out_valid(out_valid), .out_ready(out_ready), .status(status), .start_res(start_res),
    .length(length)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void clear_tables(input logic [15:0] mem);
    for (int i = 0; i < NFREE; i++) begin
      free_base[i] = 0;
      free_len[i] = 0;
    end
    for (int i = 0; i < NOWNED; i++) begin
      region_owner[i] = '0;
      region_base[i] = 0;
      region_len[i] = 0;
      region_live[i] = 1'b0;
    end
    free_len[0] = mem;
    free_cnt = (mem != 0) ? 1 : 0;
  endfunction

  function automatic void drop_free(input int k);
    for (int i = k; i + 1 < free_cnt; i++) begin
      free_base[i] = free_base[i + 1];
      free_len[i] = free_len[i + 1];
    end
    if (free_cnt > 0) free_cnt--;
  endfunction

  function automatic alloc_result_t predict_allocation(input logic k, input logic [7:0] id,
                                                      input logic [15:0] sz);
    int best, slot, p;
    int unsigned amt, rs, re;
    bit left, right;
    alloc_result_t r;
    r.st = bfpa_pkg::ST_OK;
    r.addr = '0;
    r.len = '0;
    best = -1;
    slot = -1;
    if (k == KIND_ALLOC) begin
      if (sz == 0) begin
        r.st = bfpa_pkg::ST_NOFIT;
        return r;
      end
      for (int i = 0; i < free_cnt; i++)
        if (free_len[i] >= sz && (best < 0 || free_len[i] < free_len[best])) best = i;
      if (best < 0) begin
        r.st = bfpa_pkg::ST_NOFIT;
        return r;
      end
      for (int i = 0; i < NOWNED; i++)
        if (!region_live[i] && slot < 0) slot = i;
      if (slot < 0) begin
        r.st = bfpa_pkg::ST_FULL;
        return r;
      end
      r.addr = free_base[best];
      r.len = sz;
      region_live[slot] = 1'b1;
      region_owner[slot] = id;
      region_base[slot] = free_base[best];
      region_len[slot] = sz;
      free_base[best] = (free_base[best] + sz) & 16'hFFFF;
      free_len[best] -= sz;
      if (free_len[best] == 0) drop_free(best);
      return r;
    end
    for (int i = 0; i < NOWNED; i++)
      if (region_live[i] && region_owner[i] == id && slot < 0) slot = i;
    if (slot < 0) begin
      r.st = bfpa_pkg::ST_NOOWNER;
      return r;
    end
    rs = region_base[slot];
    amt = (sz < region_len[slot]) ? sz : region_len[slot];
    if (amt == 0) begin
      r.addr = rs;
      return r;
    end
    re = rs + amt;
    p = 0;
    while (p < free_cnt && free_base[p] < rs) p++;
    left = (p > 0) && (free_base[p - 1] + free_len[p - 1] == rs);
    right = (p < free_cnt) && (free_base[p] == re);
    if (!left && !right && free_cnt >= NFREE) begin
      r.st = bfpa_pkg::ST_FULL;
      return r;
    end
    if (left && right) begin
      free_len[p - 1] += amt + free_len[p];
      drop_free(p);
    end else if (left) begin
      free_len[p - 1] += amt;
    end else if (right) begin
      free_base[p] = rs;
      free_len[p] += amt;
    end else begin
      for (int i = free_cnt; i > p; i--) begin
        free_base[i] = free_base[i - 1];
        free_len[i] = free_len[i - 1];
      end
      free_base[p] = rs;
      free_len[p] = amt;
      free_cnt++;
    end
    region_base[slot] = re & 16'hFFFF;
    region_len[slot] -= amt;
    if (region_len[slot] == 0) region_live[slot] = 1'b0;
    r.addr = rs;
    r.len = amt;
    return r;
  endfunction

  // The valid stays high after acceptance; the next call, or any wait, decides its level.
  task automatic send_request(input logic k, input logic [7:0] id, input logic [15:0] sz);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    owner_id <= id;
    size <= sz;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, predict_allocation(k, id, sz)};
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_memory_size(input logic [15:0] mem);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mem;
    @(posedge clk);
    cfg_we <= 1'b0;
    clear_tables(mem);
  endtask

  task automatic test_basic_cases();
    write_memory_size(16'd640);
    send_request(KIND_ALLOC, 8'd0, 16'd0);
    send_request(KIND_ALLOC, 8'd0, 16'd1);
    send_request(KIND_ALLOC, 8'hFF, 16'hFFFF);
    send_request(KIND_ALLOC, 8'hFF, 16'd639);
    send_request(KIND_RELEASE, 8'd77, 16'd1);
    send_request(KIND_RELEASE, 8'd0, 16'd0);
    send_request(KIND_RELEASE, 8'd0, 16'hFFFF);
    send_request(KIND_RELEASE, 8'hFF, 16'd100);
    send_request(KIND_ALLOC, 8'd5, 16'd200);
    send_request(KIND_ALLOC, 8'd6, 16'd340);
    send_request(KIND_RELEASE, 8'hFF, 16'd600);
    send_request(KIND_ALLOC, 8'd7, 16'd539);
    write_memory_size(16'd0);
    send_request(KIND_ALLOC, 8'd1, 16'd1);
    send_request(KIND_RELEASE, 8'd1, 16'd1);
    write_memory_size(16'hFFFF);
    send_request(KIND_ALLOC, 8'd2, 16'hFFFF);
    send_request(KIND_RELEASE, 8'd2, 16'hFFFF);
    write_memory_size(16'd1);
    send_request(KIND_ALLOC, 8'd3, 16'd2);
    send_request(KIND_ALLOC, 8'd3, 16'd1);
  endtask

  task automatic test_owned_table_full();
    write_memory_size(16'd640);
    for (int i = 0; i < NOWNED; i++) send_request(KIND_ALLOC, i[7:0], 16'd2);
    send_request(KIND_ALLOC, 8'd99, 16'd1);
  endtask

  task automatic test_free_table_full();
    for (int i = 0; i < NOWNED; i++) send_request(KIND_RELEASE, i[7:0], 16'd1);
    send_request(KIND_RELEASE, 8'd0, 16'd100);
    send_request(KIND_RELEASE, 8'd15, 16'd1);
  endtask

  task automatic test_random_traffic(input logic [15:0] mem, input int count);
    logic k;
    logic [7:0] id;
    logic [15:0] sz;
    int span;
    write_memory_size(mem);
    span = (mem > 16) ? mem / 8 : 2;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      k = ($urandom_range(0, 99) < 55) ? KIND_ALLOC : KIND_RELEASE;
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
      case ($urandom_range(0, 19))
        0: sz = 16'($urandom);
        1: sz = 16'd0;
        2: sz = 16'hFFFF;
        default: sz = 16'($urandom_range(1, span));
      endcase
      send_request(k, id, sz);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_output_backpressure();
    write_memory_size(16'd640);
    hold_request = 300;
    no_gaps = 1'b1;
    for (int n = 0; n < 40; n++)
      send_request(n[0] ? KIND_RELEASE : KIND_ALLOC, 8'($urandom_range(0, 5)),
                   16'($urandom_range(1, 60)));
    no_gaps = 1'b0;
    wait_for_results();
    for (int n = 0; n < 20; n++)
      send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 5)),
                   16'($urandom_range(0, 90)));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    kind = KIND_ALLOC;
    owner_id = '0;
    size = '0;
    mismatches = 0;
    no_gaps = 1'b0;
    hold_request = 0;
    clear_tables(bfpa_pkg::RESET_MEMORY_SIZE);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_request(KIND_ALLOC, 8'd9, 16'd640);
    send_request(KIND_RELEASE, 8'd9, 16'd640);
    test_basic_cases();
    test_owned_table_full();
    test_free_table_full();
    test_output_backpressure();
    test_random_traffic(16'd640, 450);
    test_random_traffic(16'hFFFF, 400);
    test_random_traffic(16'd1, 150);
    test_random_traffic(16'd100, 450);
    test_random_traffic(16'($urandom_range(1, 65535)), 400);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int w;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        w = no_gaps ? 0 : $urandom_range(0, 11);
        if (w > 0) begin
          out_ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result: status %0d start %0d length %0d",
                   status, start_res, length);
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st || start_res !== e.addr || length !== e.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d start %0d length %0d, got %0d %0d %0d",
                     e.st, e.addr, e.len, status, start_res, length);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
